// ----- rtl/core/sbr_pkg.sv -----
// sbr_pkg: shared constants, types and helpers of the stream byte reassembler
// no dependencies; imported by sbr_addsub and stream_byte_reassembler
package sbr_pkg;

  localparam int WINDOW_BYTES = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int CAP          = (WINDOW_BYTES < MAX_RESULTS) ? WINDOW_BYTES : MAX_RESULTS;
  localparam int IDX_W        = 64;
  localparam int BYTE_W       = 8;
  localparam int ROOM_W       = 6;
  localparam int CNT_W        = $clog2(CAP + 1);
  localparam int SLOT_W       = $clog2(WINDOW_BYTES);
  localparam int PEND_W       = $clog2(WINDOW_BYTES + 1);
  localparam int PCNT_W       = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END,
    ST_CMPN,
    ST_CMPE,
    ST_SCAN,
    ST_ADV,
    ST_CLOSE,
    ST_OUT,
    ST_RD
  } sbr_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             sub;
  } sbr_alu_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] sum;
    logic             carry;
  } sbr_alu_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(WINDOW_BYTES - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  // adds an offset of up to the window size to a slot, wrapping once
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W:0]   d);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + d;
    if (t >= (SLOT_W+1)'(WINDOW_BYTES)) begin
      t = t - (SLOT_W+1)'(WINDOW_BYTES);
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/sbr_addsub.sv -----
// sbr_addsub: the shared 64-bit add/subtract unit of the sequencer
// depends on sbr_pkg (request and response structs)
module sbr_addsub (
  input  sbr_pkg::sbr_alu_req_t req,
  output sbr_pkg::sbr_alu_rsp_t rsp
);
  import sbr_pkg::*;

  logic [IDX_W:0]   total;
  logic [IDX_W-1:0] b_op;

  // carry out on subtract means a >= b
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + (IDX_W+1)'(req.sub);
  assign rsp.sum   = total[IDX_W-1:0];
  assign rsp.carry = total[IDX_W];

endmodule

// ----- rtl/core/sbr_ram.sv -----
// sbr_ram: generic single-write, single-read memory with registered read data
// no dependencies
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/stream_byte_reassembler.sv -----
// stream_byte_reassembler: top level, sequencer around one shared 64-bit adder
// depends on sbr_pkg, sbr_addsub, sbr_ram
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    stream_index, data_byte, has_byte,
//                                              ends_stream, room
//   out_     output     out_valid / out_stall  out_valid, out_byte, last_of_run,
//                                              stream_closed, pending_count
//
// the time an item takes, whether it emits nothing or k bytes, is set by the one
// 64-bit adder used for every index compare, the one-slot-per-cycle scan of the
// valid bits and the single registered ram read
// reset is synchronous and clears the valid bits at once, no clearing pass
// in_stall is low only in idle; the output register lets a new item in while
// the last result still waits on out_stall
module stream_byte_reassembler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbr_pkg::IDX_W-1:0]    in_stream_index,
  input  logic [sbr_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_has_byte,
  input  logic                         in_ends_stream,
  input  logic [sbr_pkg::ROOM_W-1:0]   in_room,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_out_valid,
  output logic [sbr_pkg::BYTE_W-1:0]   out_out_byte,
  output logic                         out_last_of_run,
  output logic                         out_stream_closed,
  output logic [sbr_pkg::PCNT_W-1:0]   out_pending_count
);
  import sbr_pkg::*;

  sbr_state_t state_r, state_nxt;

  // latched item
  logic [IDX_W-1:0]  idx_r;
  logic [BYTE_W-1:0] byte_r;
  logic              has_r;
  logic              ends_r;
  logic [CNT_W-1:0]  cap_r;

  // stream state
  logic [IDX_W-1:0]        next_index_r;
  logic [IDX_W-1:0]        end_index_r;
  logic                    end_known_r;
  logic                    closed_r;
  logic [WINDOW_BYTES-1:0] slot_valid_r;
  logic [PEND_W-1:0]       pending_r;
  logic [SLOT_W-1:0]       head_r;

  // per-item working registers
  logic              off_ok_r;
  logic              off_zero_r;
  logic [SLOT_W-1:0] store_slot_r;
  logic              direct_r;
  logic [CNT_W-1:0]  run_r;
  logic [SLOT_W-1:0] scan_ptr_r;
  logic [SLOT_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0]  rem_r;
  logic              first_r;

  // output register
  logic              out_valid_r;
  logic              out_bv_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_closed_r;
  logic [PCNT_W-1:0] out_pend_r;

  sbr_alu_req_t alu_req;
  sbr_alu_rsp_t alu_rsp;

  logic              accept;
  logic              take_c;
  logic              direct_c;
  logic              scan_go;
  logic              out_load;
  logic [CNT_W-1:0]  k_cnt;
  logic [CNT_W-1:0]  cap_in;
  logic              off_ok_c;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [PEND_W+PCNT_W-1:0] pend_ext;

  sbr_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_slot_r),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign k_cnt    = run_r + CNT_W'(1);
  assign cap_in   = (in_room > ROOM_W'(CAP)) ? CNT_W'(CAP) : CNT_W'(in_room);

  // offset check against next_index: no borrow, high bits zero, below the cap
  assign off_ok_c = alu_rsp.carry && (alu_rsp.sum[IDX_W-1:CNT_W] == '0) &&
                    (alu_rsp.sum[CNT_W-1:0] < cap_r);

  // in ST_CMPE the adder gives idx - end_index; carry means at or past the end
  assign take_c   = !closed_r && has_r && off_ok_r && !(end_known_r && alu_rsp.carry);
  assign direct_c = take_c && off_zero_r;

  // drain continues while room is left and the following slot is filled
  assign scan_go  = (({1'b0, run_r} + (CNT_W+1)'(1)) < {1'b0, cap_r}) &&
                    slot_valid_r[scan_ptr_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_END;
      ST_END:   state_nxt = ST_CMPN;
      ST_CMPN:  state_nxt = ST_CMPE;
      ST_CMPE:  state_nxt = direct_c ? ST_SCAN : ST_CLOSE;
      ST_SCAN:  if (!scan_go) state_nxt = ST_ADV;
      ST_ADV:   state_nxt = ST_CLOSE;
      ST_CLOSE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = (rem_r > CNT_W'(1)) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD:    state_nxt = ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: adder operands, ram strobes, input stall
  always_comb begin
    alu_req.a   = end_index_r;
    alu_req.b   = next_index_r;
    alu_req.sub = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_END: begin
        alu_req.a   = idx_r;
        alu_req.b   = IDX_W'(has_r);
        alu_req.sub = 1'b0;
      end
      ST_CMPN: begin
        alu_req.a = idx_r;
        alu_req.b = next_index_r;
      end
      ST_CMPE: begin
        alu_req.a = idx_r;
        alu_req.b = end_index_r;
        ram_we    = take_c && !off_zero_r;
      end
      ST_ADV: begin
        alu_req.a   = next_index_r;
        alu_req.b   = IDX_W'(k_cnt);
        alu_req.sub = 1'b0;
      end
      ST_RD: ram_re = 1'b1;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_index_r <= '0;
      end_index_r  <= '0;
      end_known_r  <= 1'b0;
      closed_r     <= 1'b0;
      slot_valid_r <= '0;
      pending_r    <= '0;
      head_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_END: begin
          if (!closed_r && ends_r) begin
            end_index_r <= alu_rsp.sum;
            end_known_r <= 1'b1;
          end
        end
        ST_CMPE: begin
          if (direct_c) begin
            // a slot left behind by a capped drain goes with the direct byte
            if (slot_valid_r[head_r]) begin
              slot_valid_r[head_r] <= 1'b0;
              pending_r            <= pending_r - PEND_W'(1);
            end
          end else if (take_c) begin
            if (!slot_valid_r[store_slot_r]) begin
              slot_valid_r[store_slot_r] <= 1'b1;
              pending_r                  <= pending_r + PEND_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            slot_valid_r[scan_ptr_r] <= 1'b0;
            pending_r                <= pending_r - PEND_W'(1);
          end
        end
        ST_ADV: begin
          next_index_r <= alu_rsp.sum;
          head_r       <= slot_add(head_r, (SLOT_W+1)'(k_cnt));
        end
        ST_CLOSE: begin
          if (end_known_r && (alu_rsp.sum == '0)) begin
            closed_r <= 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_stream_index;
      byte_r <= in_data_byte;
      has_r  <= in_has_byte;
      ends_r <= in_ends_stream;
      cap_r  <= cap_in;
    end
    case (state_r)
      ST_CMPN: begin
        off_ok_r     <= off_ok_c;
        off_zero_r   <= (alu_rsp.sum[CNT_W-1:0] == '0);
        store_slot_r <= slot_add(head_r, (SLOT_W+1)'(alu_rsp.sum[CNT_W-1:0]));
      end
      ST_CMPE: begin
        direct_r   <= direct_c;
        run_r      <= '0;
        scan_ptr_r <= slot_inc(head_r);
        rd_ptr_r   <= slot_inc(head_r);
      end
      ST_SCAN: begin
        if (scan_go) begin
          run_r      <= run_r + CNT_W'(1);
          scan_ptr_r <= slot_inc(scan_ptr_r);
        end
      end
      ST_CLOSE: begin
        rem_r   <= direct_r ? k_cnt : '0;
        first_r <= 1'b1;
      end
      ST_OUT: begin
        if (out_load) begin
          first_r <= 1'b0;
          if (rem_r != '0) begin
            rem_r <= rem_r - CNT_W'(1);
          end
        end
      end
      ST_RD: rd_ptr_r <= slot_inc(rd_ptr_r);
      default: ;
    endcase
    if (out_load) begin
      out_bv_r     <= (rem_r != '0);
      out_last_r   <= (rem_r <= CNT_W'(1));
      out_closed_r <= closed_r;
      out_pend_r   <= (pend_ext > (PEND_W+PCNT_W)'(63)) ? PCNT_W'(63) : pend_ext[PCNT_W-1:0];
      if (rem_r == '0) begin
        out_byte_r <= '0;
      end else if (first_r) begin
        out_byte_r <= byte_r;
      end else begin
        out_byte_r <= ram_rdata;
      end
    end
  end

  assign pend_ext = (PEND_W+PCNT_W)'(pending_r);

  assign out_valid         = out_valid_r;
  assign out_out_valid     = out_bv_r;
  assign out_out_byte      = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_stream_closed = out_closed_r;
  assign out_pending_count = out_pend_r;

  // pending counter tracks the valid bits exactly
  a_pending_matches: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == PEND_W'($countones(slot_valid_r)))
    else $error("pending count differs from valid slots");

  // the stream never reopens
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed flag dropped");

  // the drain never runs past the room limit
  a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (run_r < cap_r))
    else $error("drain exceeded room");

  // an empty result is always marked as the last of its run
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_valid) |-> out_last_of_run)
    else $error("empty result not marked last");

endmodule

// ----- test/stream_byte_reassembler_test.sv -----
// stream_byte_reassembler_test: self-checking bench for the byte stream reassembler
// holds a scoreboard class that predicts every result item and the tasks that drive the
// ports; depends on sbr_pkg and the stream_byte_reassembler top level
`timescale 1ns / 1ps

class reassembly_scoreboard;
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       last;
    logic       closed;
    logic [5:0] pending;
  } result_t;

  logic [63:0] next_idx = '0;
  logic [63:0] end_idx = '0;
  logic        end_seen = 1'b0;
  logic        closed = 1'b0;
  logic [7:0]  window_data [sbr_pkg::WINDOW_BYTES];
  logic        slot_full [sbr_pkg::WINDOW_BYTES];
  result_t     expected_results [$];
  int          mismatch_count = 0;

  function new();
    foreach (slot_full[i]) begin
      slot_full[i] = 1'b0;
      window_data[i] = '0;
    end
  endfunction

  // works out the result items of one accepted input item
  function void note_item(input logic [63:0] idx, input logic [7:0] data, input logic has,
                          input logic ends, input logic [5:0] room);
    int unsigned cap;
    int unsigned pend;
    int unsigned slot;
    logic [63:0] off;
    logic [7:0]  emitted [$];
    result_t     res;
    cap = 32'(room);
    if (cap > sbr_pkg::WINDOW_BYTES) cap = sbr_pkg::WINDOW_BYTES;
    if (cap > sbr_pkg::MAX_RESULTS) cap = sbr_pkg::MAX_RESULTS;
    if (!closed) begin
      if (ends) begin
        end_idx = idx + {63'b0, has};
        end_seen = 1'b1;
      end
      if (has && idx >= next_idx && !(end_seen && idx >= end_idx)) begin
        off = idx - next_idx;
        if (off < 64'(cap)) begin
          slot = int'(idx % 64'(sbr_pkg::WINDOW_BYTES));
          if (off == 0) begin
            emitted.push_back(data);
            slot_full[slot] = 1'b0;
            next_idx++;
            slot = int'(next_idx % 64'(sbr_pkg::WINDOW_BYTES));
            while (emitted.size() < cap && slot_full[slot]) begin
              emitted.push_back(window_data[slot]);
              slot_full[slot] = 1'b0;
              next_idx++;
              slot = int'(next_idx % 64'(sbr_pkg::WINDOW_BYTES));
            end
          end else begin
            window_data[slot] = data;
            slot_full[slot] = 1'b1;
          end
        end
      end
      if (end_seen && end_idx == next_idx) closed = 1'b1;
    end
    pend = 0;
    foreach (slot_full[i]) pend += 32'(slot_full[i]);
    if (pend > 63) pend = 63;
    if (emitted.size() == 0) begin
      res = {1'b0, 8'h00, 1'b1, closed, 6'(pend)};
      expected_results.push_back(res);
    end else begin
      foreach (emitted[i]) begin
        res = {1'b1, emitted[i], (i == emitted.size() - 1), closed, 6'(pend)};
        expected_results.push_back(res);
      end
    end
  endfunction

  function void check_result(input logic has_data, input logic [7:0] data, input logic last,
                             input logic closed_now, input logic [5:0] pending);
    result_t got;
    result_t want;
    got = {has_data, data, last, closed_now, pending};
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result valid=%0b byte=%h last=%0b closed=%0b pending=%0d",
               $time, got.has_data, got.data, got.last, got.closed, got.pending);
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: expected valid=%0b byte=%h last=%0b closed=%0b pending=%0d",
                 $time, want.has_data, want.data, want.last, want.closed, want.pending);
        $display("%0t: actual   valid=%0b byte=%h last=%0b closed=%0b pending=%0d",
                 $time, got.has_data, got.data, got.last, got.closed, got.pending);
      end
    end
  endfunction
endclass

module stream_byte_reassembler_test;
  // generous bound, far above the slowest run with every item at its worst
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 368;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [sbr_pkg::IDX_W-1:0]   in_stream_index = '0;
  logic [sbr_pkg::BYTE_W-1:0]  in_data_byte = '0;
  logic                        in_has_byte = 1'b0;
  logic                        in_ends_stream = 1'b0;
  logic [sbr_pkg::ROOM_W-1:0]  in_room = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_out_valid;
  logic [sbr_pkg::BYTE_W-1:0]  out_out_byte;
  logic                        out_last_of_run;
  logic                        out_stream_closed;
  logic [sbr_pkg::PCNT_W-1:0]  out_pending_count;

  reassembly_scoreboard sb = new();
  int items_sent = 0;
  int calm_left = 0;
  int cycles = 0;

  stream_byte_reassembler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_index   (in_stream_index),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_ends_stream    (in_ends_stream),
    .in_room           (in_room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_valid     (out_out_valid),
    .out_out_byte      (out_out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_stream_closed (out_stream_closed),
    .out_pending_count (out_pending_count)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offers one item, holds it until accepted, then maybe idles for a while
  task automatic send_item(input logic [63:0] idx, input logic [7:0] data, input logic has,
                           input logic ends, input logic [5:0] room);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_stream_index <= idx;
    in_data_byte <= data;
    in_has_byte <= has;
    in_ends_stream <= ends;
    in_room <= room;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(idx, data, has, ends, room);
    items_sent++;
    gap = 0;
    if (calm_left > 0) begin
      // stretch of back-to-back items
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm_left = $urandom_range(20, 60);
      end else if (r < 55) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a run of bytes just ahead of the next expected index, in shuffled order;
  // the orderly form holds back offset 0 until the rest of the window is stored,
  // so the final byte drains the whole window in one burst
  task automatic run_burst(input int len, input bit orderly);
    logic [63:0] base;
    int          offs [$];
    int          i;
    int          j;
    int          t;
    logic [5:0]  room;
    logic        has;
    base = sb.next_idx;
    // an end mark at or near the window would block or close the stream early,
    // so push it far out first
    if (sb.end_seen && !(sb.end_idx > base + 64)) begin
      send_item(base + 4096, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 6'd32);
    end
    for (i = orderly ? 1 : 0; i < len; i++) offs.push_back(i);
    for (i = offs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = offs[i];
      offs[i] = offs[j];
      offs[j] = t;
    end
    if (orderly) offs.push_back(0);
    for (i = 0; i < offs.size(); i++) begin
      has = orderly ? 1'b1 : ($urandom_range(0, 19) != 0);
      room = (orderly || $urandom_range(0, 99) < 80) ? 6'd32 : 6'($urandom_range(0, 32));
      send_item(base + 64'(offs[i]), 8'($urandom_range(0, 255)), has, 1'b0, room);
      // now and then a repeat of an earlier offset: stale or an overwrite
      if (!orderly && $urandom_range(0, 99) < 8) begin
        send_item(base + 64'(offs[$urandom_range(0, i)]), 8'($urandom_range(0, 255)), 1'b1,
                  1'b0, 6'd32);
      end
    end
  endtask

  // every result item taken by the bench goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_out_valid, out_out_byte, out_last_of_run, out_stream_closed,
                      out_pending_count);
    end
  end

  // result side back-pressure: free runs, short stalls, long stalls
  initial begin
    int r;
    int len;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 30);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        len = $urandom_range(30, 120);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len) @(posedge clk);
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          r;
    int          len;
    logic [63:0] idx;
    logic [63:0] base;
    logic        has;
    logic        ends;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_item(64'd0, 8'hFF, 1'b1, 1'b0, 6'd0);       // no room: even the next byte is dropped
    send_item(64'd3, 8'hA5, 1'b1, 1'b0, 6'd32);      // stored ahead
    send_item(64'd1, 8'h11, 1'b1, 1'b0, 6'd32);      // stored ahead
    send_item(64'd2, 8'h00, 1'b0, 1'b0, 6'd32);      // empty marker, no end
    send_item(64'd0, 8'h00, 1'b1, 1'b0, 6'd1);       // room 1 stops the drain, slot 1 left over
    send_item(64'd1, 8'h5A, 1'b1, 1'b0, 6'd1);       // direct byte on a left-over slot
    send_item(64'd0, 8'hC3, 1'b1, 1'b0, 6'd32);      // stale
    send_item(64'd2, 8'h22, 1'b1, 1'b0, 6'd32);      // emits and drains one stored byte
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b0, 6'd32);  // far outside the window
    send_item(64'd10, 8'h77, 1'b1, 1'b1, 6'd32);     // end mark with byte, byte kept
    send_item(64'd11, 8'h88, 1'b1, 1'b0, 6'd32);     // at the end index: dropped
    send_item(64'd5000, 8'h00, 1'b0, 1'b1, 6'd32);   // later mark replaces the end
    send_item(64'd1, 8'h00, 1'b0, 1'b1, 6'd32);      // end below next index: no close
    send_item(64'd4, 8'h44, 1'b1, 1'b0, 6'd32);      // beyond that end: dropped
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, 6'd31);  // end wraps to zero
    send_item(64'd6000, 8'h00, 1'b0, 1'b1, 6'd32);   // end far out again
    send_item(64'd5, 8'h55, 1'b1, 1'b0, 6'd32);
    send_item(64'd4, 8'h44, 1'b1, 1'b0, 6'd32);      // emits two
    send_item(64'd35, 8'h35, 1'b1, 1'b0, 6'd32);     // stored at offset 29, near the top of the window

    // whole window at once, 32 results from one item
    run_burst(sbr_pkg::WINDOW_BYTES, 1'b1);

    // random part: mostly well-formed runs, some noise and end marks
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 32);
        run_burst(len, 1'b0);
      end else if (r < 82) begin
        idx = {$urandom, $urandom};
        has = 1'($urandom_range(0, 1));
        ends = ($urandom_range(0, 3) == 0);
        // keep the stream open until the closing phase
        if (ends && idx + {63'b0, has} == sb.next_idx) ends = 1'b0;
        send_item(idx, 8'($urandom_range(0, 255)), has, ends, 6'($urandom_range(0, 32)));
      end else if (r < 94) begin
        send_item(sb.next_idx + 64'($urandom_range(100, 1 << 20)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b1, 6'($urandom_range(0, 32)));
      end else if (sb.next_idx >= 4) begin
        // end behind the stream, then a byte that it blocks
        send_item(sb.next_idx - 1 - 64'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'b0, 1'b1, 6'($urandom_range(0, 32)));
        send_item(sb.next_idx, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 6'd32);
      end
    end

    // empty the window, then close the stream for real
    run_burst(sbr_pkg::WINDOW_BYTES, 1'b1);
    base = sb.next_idx;
    send_item(base + 2, 8'($urandom_range(0, 255)), 1'b1, 1'b1, 6'd32);
    send_item(base + 1, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 6'd32);
    send_item(base, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 6'd32);
    // after close everything is ignored
    send_item(base + 3, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 6'd32);
    send_item(base, 8'($urandom_range(0, 255)), 1'b1, 1'b1, 6'd32);
    in_valid <= 1'b0;

    // drain, then let any late stray result show up
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
